@@ sv/dtwr_pkg.sv @@
// Shared types, codes and constants for the two-way ranging initiator sequencer.
package dtwr_pkg;

  // Event codes on the request side
  localparam logic [2:0] OP_START       = 3'd0;
  localparam logic [2:0] OP_TX_DONE     = 3'd1;
  localparam logic [2:0] OP_TX_REJECTED = 3'd2;
  localparam logic [2:0] OP_RX_GOOD     = 3'd3;
  localparam logic [2:0] OP_RX_TIMEOUT  = 3'd4;
  localparam logic [2:0] OP_RX_ERROR    = 3'd5;
  localparam logic [2:0] OP_TICK_MS     = 3'd6;

  // Radio commands on the result side
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_OFF    = 3'd1;
  localparam logic [2:0] CMD_POLL   = 3'd2;
  localparam logic [2:0] CMD_FINAL  = 3'd3;
  localparam logic [2:0] CMD_TURN   = 3'd4;
  localparam logic [2:0] CMD_WAITRX = 3'd5;
  localparam logic [2:0] CMD_REEN   = 3'd6;

  // Sequencer phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_POLL  = 3'd1;
  localparam logic [2:0] PH_FINAL = 3'd2;
  localparam logic [2:0] PH_TURN  = 3'd3;
  localparam logic [2:0] PH_WAIT  = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_TAG_ID       = 3'd0;
  localparam logic [2:0] REG_REPLY_DELAY  = 3'd1;
  localparam logic [2:0] REG_ANT_DELAY    = 3'd2;
  localparam logic [2:0] REG_TURN_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_MAX_LEN      = 3'd4;

  // Frame header expectations
  localparam logic [15:0] FC_EXPECT  = 16'h8841;
  localparam logic [15:0] PAN_EXPECT = 16'hDECA;
  localparam logic [23:0] CODE_RESP  = 24'h574110;
  localparam logic [23:0] CODE_TURN  = 24'h545552;
  localparam logic [9:0]  HEADER_CHECK_BYTES = 10'd10;

  // Targets
  localparam logic [1:0] TARGET_ONE = 2'd1;
  localparam logic [1:0] TARGET_TWO = 2'd2;

  // Register reset values
  localparam logic [7:0]  RST_TAG_ID       = 8'd0;
  localparam logic [39:0] RST_REPLY_DELAY  = 40'd319490000;
  localparam logic [15:0] RST_ANT_DELAY    = 16'd16365;
  localparam logic [15:0] RST_TURN_TIMEOUT = 16'd50;
  localparam logic [9:0]  RST_MAX_LEN      = 10'd127;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [7:0]  tag_id;
    logic [39:0] reply_delay_ticks;
    logic [15:0] tx_antenna_delay;
    logic [15:0] turn_timeout_ms;
    logic [9:0]  max_frame_length;
  } cfg_t;

  // One registered event, with the reply time sum already formed
  typedef struct packed {
    logic [2:0]  op;
    logic [39:0] timestamp;
    logic [9:0]  frame_length;
    logic [15:0] frame_control;
    logic [15:0] pan_id;
    logic [7:0]  anchor_byte;
    logic [7:0]  tag_byte;
    logic [23:0] function_code;
    logic [39:0] reply_sum;
  } item_t;

endpackage

@@ sv/ds_twr_token_initiator.sv @@
// Top level of the double-sided two-way ranging initiator sequencer.
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | tuser: op; tdata: radio event fields
//  m_axis   | out       | tuser: command; tdata: target, sequence, timestamps
//  cfg      | in        | cfg_index selects register, cfg_data is its value
//
// One event per cycle sustained while the result stream is not stalled. An accepted
// request passes the input register, then decision logic into the result register.
// The reply time sum is formed in the input register, the final timestamp add
// sits in the decision stage. Reset is synchronous and restores register
// defaults and the idle phase. A stalled result holds while the input register
// still takes one more request.
module ds_twr_token_initiator (
  input  logic         clk,
  input  logic         rst,
  // Event stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata, low bit up: timestamp[39:0], frame_length[49:40],
  // frame_control[65:50], pan_id[81:66], anchor_byte[89:82],
  // tag_byte[97:90], function_code[121:98], zero fill to 127
  input  logic [127:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,   // op
  // Result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata, low bit up: target_id[1:0], sequence_number[9:2],
  // delayed_tx_time[41:10], poll_sent_time[81:42], response_time[121:82],
  // final_sent_time[161:122], phase_out[164:162], zero fill to 167
  output logic [167:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,   // command
  // Configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [39:0]  cfg_data
);

  dtwr_pkg::cfg_t  cfg;
  dtwr_pkg::item_t item;
  logic            full;
  logic            take;

  dtwr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dtwr_in u_in (
    .clk               (clk),
    .rst               (rst),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .reply_delay_ticks (cfg.reply_delay_ticks),
    .take              (take),
    .full              (full),
    .item              (item)
  );

  dtwr_step u_step (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .full          (full),
    .item          (item),
    .take          (take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

@@ sv/dtwr_cfg.sv @@
// Configuration register file of the ranging initiator.
module dtwr_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [39:0]      cfg_data,
  output dtwr_pkg::cfg_t   cfg
);

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tag_id            <= dtwr_pkg::RST_TAG_ID;
      cfg.reply_delay_ticks <= dtwr_pkg::RST_REPLY_DELAY;
      cfg.tx_antenna_delay  <= dtwr_pkg::RST_ANT_DELAY;
      cfg.turn_timeout_ms   <= dtwr_pkg::RST_TURN_TIMEOUT;
      cfg.max_frame_length  <= dtwr_pkg::RST_MAX_LEN;
    end else if (cfg_valid) begin
      case (cfg_index)
        dtwr_pkg::REG_TAG_ID:       cfg.tag_id <= cfg_data[7:0];
        dtwr_pkg::REG_REPLY_DELAY:  cfg.reply_delay_ticks <= cfg_data;
        dtwr_pkg::REG_ANT_DELAY:    cfg.tx_antenna_delay <= cfg_data[15:0];
        dtwr_pkg::REG_TURN_TIMEOUT: cfg.turn_timeout_ms <= cfg_data[15:0];
        dtwr_pkg::REG_MAX_LEN:      cfg.max_frame_length <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/dtwr_in.sv @@
// Input register stage: unpacks an event and forms the reply time sum.
module dtwr_in (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [127:0]       s_axis_tdata,
  input  logic [2:0]         s_axis_tuser,
  input  logic [39:0]        reply_delay_ticks,
  input  logic               take,
  output logic               full,
  output dtwr_pkg::item_t    item
);

  logic accept;

  assign s_axis_tready = !full || take;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= accept || (full && !take);
    end
  end

  // Payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item.op            <= s_axis_tuser;
      item.timestamp     <= s_axis_tdata[39:0];
      item.frame_length  <= s_axis_tdata[49:40];
      item.frame_control <= s_axis_tdata[65:50];
      item.pan_id        <= s_axis_tdata[81:66];
      item.anchor_byte   <= s_axis_tdata[89:82];
      item.tag_byte      <= s_axis_tdata[97:90];
      item.function_code <= s_axis_tdata[121:98];
      item.reply_sum     <= s_axis_tdata[39:0] + reply_delay_ticks;
    end
  end

endmodule

@@ sv/dtwr_step.sv @@
// Sequencer state, per-event decision logic and result register.
module dtwr_step (
  input  logic               clk,
  input  logic               rst,
  input  dtwr_pkg::cfg_t     cfg,
  input  logic               full,
  input  dtwr_pkg::item_t    item,
  output logic               take,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [167:0]       m_axis_tdata,
  output logic [2:0]         m_axis_tuser
);

  // Sequencer state
  logic [2:0]  phase, phase_next;
  logic [1:0]  target, target_next;
  logic [7:0]  seq_count, seq_count_next;
  logic [39:0] poll_time, poll_time_next;
  logic [15:0] wait_ms, wait_ms_next;

  // Result fields
  logic [2:0]  cmd;
  logic [31:0] dly;
  logic [39:0] pst, rsp, fst;

  // Helper outcomes
  logic [2:0]  adv_phase, adv_cmd;
  logic [1:0]  adv_target;
  logic        resp_ok, len_ok, len_over;
  logic [31:0] sum_hi;
  logic [39:0] fst_calc;

  assign take = full && (!m_axis_tvalid || m_axis_tready);

  // Move to the next target, or to TURN after target two
  always_comb begin
    if (target == dtwr_pkg::TARGET_ONE) begin
      adv_target = dtwr_pkg::TARGET_TWO;
      adv_phase  = dtwr_pkg::PH_POLL;
      adv_cmd    = dtwr_pkg::CMD_POLL;
    end else begin
      adv_target = target;
      adv_phase  = dtwr_pkg::PH_TURN;
      adv_cmd    = dtwr_pkg::CMD_TURN;
    end
  end

  // Frame checks and final timestamp prediction
  assign len_ok   = item.frame_length >= dtwr_pkg::HEADER_CHECK_BYTES;
  assign len_over = item.frame_length > cfg.max_frame_length;
  assign resp_ok  = len_ok && !len_over
                 && item.anchor_byte == {6'd0, target}
                 && item.tag_byte == cfg.tag_id
                 && item.frame_control == dtwr_pkg::FC_EXPECT
                 && item.pan_id == dtwr_pkg::PAN_EXPECT
                 && item.function_code == dtwr_pkg::CODE_RESP;
  assign sum_hi   = item.reply_sum[39:8];
  assign fst_calc = {sum_hi[31:1], 9'd0} + {24'd0, cfg.tx_antenna_delay};

  // Event decode
  always_comb begin
    phase_next     = phase;
    target_next    = target;
    seq_count_next = seq_count;
    poll_time_next = poll_time;
    wait_ms_next   = wait_ms;
    cmd = dtwr_pkg::CMD_NONE;
    dly = 32'd0;
    pst = 40'd0;
    rsp = 40'd0;
    fst = 40'd0;
    if (item.op == dtwr_pkg::OP_START) begin
      target_next = dtwr_pkg::TARGET_ONE;
      phase_next  = dtwr_pkg::PH_POLL;
      cmd         = dtwr_pkg::CMD_POLL;
    end else if (phase != dtwr_pkg::PH_IDLE) begin
      case (item.op)
        dtwr_pkg::OP_TX_DONE: begin
          if (phase == dtwr_pkg::PH_POLL) begin
            poll_time_next = item.timestamp;
          end else if (phase == dtwr_pkg::PH_FINAL) begin
            seq_count_next = seq_count + 8'd1;
            target_next    = adv_target;
            phase_next     = adv_phase;
            cmd            = adv_cmd;
          end else if (phase == dtwr_pkg::PH_TURN) begin
            wait_ms_next = 16'd0;
            phase_next   = dtwr_pkg::PH_WAIT;
            cmd          = dtwr_pkg::CMD_WAITRX;
          end
        end
        dtwr_pkg::OP_TX_REJECTED: begin
          if (phase == dtwr_pkg::PH_POLL || phase == dtwr_pkg::PH_FINAL) begin
            target_next = adv_target;
            phase_next  = adv_phase;
            cmd         = adv_cmd;
          end else if (phase == dtwr_pkg::PH_TURN) begin
            wait_ms_next = 16'd0;
            phase_next   = dtwr_pkg::PH_WAIT;
            cmd          = dtwr_pkg::CMD_WAITRX;
          end
        end
        dtwr_pkg::OP_RX_GOOD: begin
          if (phase == dtwr_pkg::PH_POLL) begin
            if (resp_ok) begin
              dly        = sum_hi;
              fst        = fst_calc;
              pst        = poll_time;
              rsp        = item.timestamp;
              phase_next = dtwr_pkg::PH_FINAL;
              cmd        = dtwr_pkg::CMD_FINAL;
            end else begin
              target_next = adv_target;
              phase_next  = adv_phase;
              cmd         = adv_cmd;
            end
          end else if (phase == dtwr_pkg::PH_WAIT) begin
            if (len_over) begin
              wait_ms_next = 16'd0;
              phase_next   = dtwr_pkg::PH_WAIT;
              cmd          = dtwr_pkg::CMD_WAITRX;
            end else if (len_ok && item.function_code == dtwr_pkg::CODE_TURN) begin
              target_next = dtwr_pkg::TARGET_ONE;
              phase_next  = dtwr_pkg::PH_POLL;
              cmd         = dtwr_pkg::CMD_POLL;
            end else begin
              cmd = dtwr_pkg::CMD_REEN;
            end
          end else begin
            cmd = dtwr_pkg::CMD_OFF;
          end
        end
        dtwr_pkg::OP_RX_TIMEOUT: begin
          if (phase == dtwr_pkg::PH_WAIT) begin
            target_next = dtwr_pkg::TARGET_ONE;
            phase_next  = dtwr_pkg::PH_POLL;
            cmd         = dtwr_pkg::CMD_POLL;
          end else begin
            target_next = adv_target;
            phase_next  = adv_phase;
            cmd         = adv_cmd;
          end
        end
        dtwr_pkg::OP_RX_ERROR: begin
          if (phase == dtwr_pkg::PH_WAIT) begin
            cmd = dtwr_pkg::CMD_REEN;
          end else begin
            target_next = adv_target;
            phase_next  = adv_phase;
            cmd         = adv_cmd;
          end
        end
        dtwr_pkg::OP_TICK_MS: begin
          if (phase == dtwr_pkg::PH_WAIT) begin
            if (wait_ms >= cfg.turn_timeout_ms) begin
              target_next = dtwr_pkg::TARGET_ONE;
              phase_next  = dtwr_pkg::PH_POLL;
              cmd         = dtwr_pkg::CMD_POLL;
            end else begin
              wait_ms_next = wait_ms + 16'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // State update, one event per cycle while take is high
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= dtwr_pkg::PH_IDLE;
      target    <= dtwr_pkg::TARGET_ONE;
      seq_count <= 8'd0;
      poll_time <= 40'd0;
      wait_ms   <= 16'd0;
    end else if (take) begin
      phase     <= phase_next;
      target    <= target_next;
      seq_count <= seq_count_next;
      poll_time <= poll_time_next;
      wait_ms   <= wait_ms_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tuser <= cmd;
      m_axis_tdata <= {3'd0, phase_next, fst, rsp, pst, dly, seq_count_next, target_next};
    end
  end

endmodule

@@ tb/tb_ds_twr_token_initiator.sv @@
// Testbench for the two-way ranging initiator sequencer: predicted commands vs. result stream.
`timescale 1ns / 1ps

module tb_ds_twr_token_initiator;

  localparam int WATCHDOG_LIMIT = 1000;
  // Event code the block does not use
  localparam logic [2:0] OP_UNUSED = 3'd7;

  // One radio event as offered on the event stream
  typedef struct packed {
    logic [2:0]  op;
    logic [39:0] ts;
    logic [9:0]  flen;
    logic [15:0] fctl;
    logic [15:0] pan;
    logic [7:0]  anc;
    logic [7:0]  tag;
    logic [23:0] code;
  } radio_event_t;

  // One radio command with its frame fields
  typedef struct packed {
    logic [2:0]  cmd;
    logic [1:0]  target;
    logic [7:0]  seq;
    logic [31:0] dly;
    logic [39:0] pst;
    logic [39:0] rsp;
    logic [39:0] fst;
    logic [2:0]  phase;
  } radio_cmd_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [39:0]  cfg_data = '0;

  ds_twr_token_initiator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sequencer model state and register copies
  logic [2:0]  ph       = dtwr_pkg::PH_IDLE;
  logic [1:0]  tgt      = dtwr_pkg::TARGET_ONE;
  logic [7:0]  seq_no   = '0;
  logic [39:0] poll_ts  = '0;
  logic [15:0] wait_ms  = '0;
  logic [7:0]  reg_tag     = dtwr_pkg::RST_TAG_ID;
  logic [39:0] reg_reply   = dtwr_pkg::RST_REPLY_DELAY;
  logic [15:0] reg_ant     = dtwr_pkg::RST_ANT_DELAY;
  logic [15:0] reg_timeout = dtwr_pkg::RST_TURN_TIMEOUT;
  logic [9:0]  reg_maxlen  = dtwr_pkg::RST_MAX_LEN;

  radio_cmd_t expected_cmds[$];
  int         mismatches = 0;
  bit         gaps_on = 1'b1;
  bit         stalls_on = 1'b1;
  int         hold_request = 0;
  int         idle_cycles = 0;

  // ---------------------------------------------------------------- model
  function automatic logic [2:0] restart_ranging();
    tgt = dtwr_pkg::TARGET_ONE;
    ph  = dtwr_pkg::PH_POLL;
    return dtwr_pkg::CMD_POLL;
  endfunction

  function automatic logic [2:0] next_target();
    if (tgt == dtwr_pkg::TARGET_ONE) begin
      tgt = dtwr_pkg::TARGET_TWO;
      ph  = dtwr_pkg::PH_POLL;
      return dtwr_pkg::CMD_POLL;
    end
    ph = dtwr_pkg::PH_TURN;
    return dtwr_pkg::CMD_TURN;
  endfunction

  function automatic logic [2:0] enter_turn_wait();
    wait_ms = '0;
    ph      = dtwr_pkg::PH_WAIT;
    return dtwr_pkg::CMD_WAITRX;
  endfunction

  // Advance the model by one event and return the command it must produce
  function automatic radio_cmd_t predict_command(input radio_event_t ev);
    radio_cmd_t  r;
    logic [39:0] sum;
    logic        resp_ok;
    r = '0;
    r.cmd = dtwr_pkg::CMD_NONE;
    if (ev.op == dtwr_pkg::OP_START) begin
      r.cmd = restart_ranging();
    end else if (ph != dtwr_pkg::PH_IDLE) begin
      case (ev.op)
        dtwr_pkg::OP_TX_DONE: begin
          if (ph == dtwr_pkg::PH_POLL) begin
            poll_ts = ev.ts;
          end else if (ph == dtwr_pkg::PH_FINAL) begin
            seq_no = seq_no + 8'd1;
            r.cmd = next_target();
          end else if (ph == dtwr_pkg::PH_TURN) begin
            r.cmd = enter_turn_wait();
          end
        end
        dtwr_pkg::OP_TX_REJECTED: begin
          if (ph == dtwr_pkg::PH_POLL || ph == dtwr_pkg::PH_FINAL) r.cmd = next_target();
          else if (ph == dtwr_pkg::PH_TURN) r.cmd = enter_turn_wait();
        end
        dtwr_pkg::OP_RX_GOOD: begin
          if (ph == dtwr_pkg::PH_POLL) begin
            resp_ok = ev.flen >= dtwr_pkg::HEADER_CHECK_BYTES && ev.flen <= reg_maxlen &&
                      ev.anc == {6'd0, tgt} && ev.tag == reg_tag &&
                      ev.fctl == dtwr_pkg::FC_EXPECT && ev.pan == dtwr_pkg::PAN_EXPECT &&
                      ev.code == dtwr_pkg::CODE_RESP;
            if (resp_ok) begin
              sum   = ev.ts + reg_reply;
              r.dly = sum[39:8];
              r.fst = {r.dly[31:1], 9'd0} + {24'd0, reg_ant};
              r.pst = poll_ts;
              r.rsp = ev.ts;
              ph    = dtwr_pkg::PH_FINAL;
              r.cmd = dtwr_pkg::CMD_FINAL;
            end else begin
              r.cmd = next_target();
            end
          end else if (ph == dtwr_pkg::PH_WAIT) begin
            if (ev.flen > reg_maxlen) r.cmd = enter_turn_wait();
            else if (ev.flen >= dtwr_pkg::HEADER_CHECK_BYTES && ev.code == dtwr_pkg::CODE_TURN)
              r.cmd = restart_ranging();
            else r.cmd = dtwr_pkg::CMD_REEN;
          end else begin
            r.cmd = dtwr_pkg::CMD_OFF;
          end
        end
        dtwr_pkg::OP_RX_TIMEOUT:
          r.cmd = (ph == dtwr_pkg::PH_WAIT) ? restart_ranging() : next_target();
        dtwr_pkg::OP_RX_ERROR:
          r.cmd = (ph == dtwr_pkg::PH_WAIT) ? dtwr_pkg::CMD_REEN : next_target();
        dtwr_pkg::OP_TICK_MS: begin
          if (ph == dtwr_pkg::PH_WAIT) begin
            if (wait_ms >= reg_timeout) r.cmd = restart_ranging();
            else wait_ms = wait_ms + 16'd1;
          end
        end
        default: ;
      endcase
    end
    r.target = tgt;
    r.seq    = seq_no;
    r.phase  = ph;
    return r;
  endfunction

  // ------------------------------------------------------------ stimulus
  function automatic logic [39:0] rand40();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return r[39:0];
    endcase
  endfunction

  function automatic radio_event_t make_event(input logic [2:0] op, input logic [39:0] ts,
                                              input logic [9:0] flen, input logic [23:0] code);
    radio_event_t ev;
    ev.op   = op;
    ev.ts   = ts;
    ev.flen = flen;
    ev.fctl = dtwr_pkg::FC_EXPECT;
    ev.pan  = dtwr_pkg::PAN_EXPECT;
    ev.anc  = {6'd0, tgt};
    ev.tag  = reg_tag;
    ev.code = code;
    return ev;
  endfunction

  function automatic logic [2:0] fault_op();
    case ($urandom_range(0, 2))
      0: return dtwr_pkg::OP_TX_REJECTED;
      1: return dtwr_pkg::OP_RX_TIMEOUT;
      default: return dtwr_pkg::OP_RX_ERROR;
    endcase
  endfunction

  // Response that matches the current target, with one header field broken at times
  function automatic radio_event_t response_frame(input logic [39:0] ts);
    radio_event_t ev;
    int           lim;
    lim = (reg_maxlen < 10) ? 10 : int'(reg_maxlen);
    ev = make_event(dtwr_pkg::OP_RX_GOOD, ts, 10'($urandom_range(10, lim)),
                    dtwr_pkg::CODE_RESP);
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 6))
        0: ev.flen = 10'($urandom_range(0, 9));
        1: ev.flen = (reg_maxlen == 10'h3FF) ? 10'd3 :
                     10'($urandom_range(int'(reg_maxlen) + 1, 1023));
        2: ev.fctl = ev.fctl ^ (16'h1 << $urandom_range(0, 15));
        3: ev.pan  = ev.pan ^ (16'h1 << $urandom_range(0, 15));
        4: ev.anc  = ev.anc ^ (8'h1 << $urandom_range(0, 7));
        5: ev.tag  = ev.tag ^ (8'h1 << $urandom_range(0, 7));
        default: ev.code = ev.code ^ (24'h1 << $urandom_range(0, 23));
      endcase
    end
    return ev;
  endfunction

  // Mostly events that fit the current phase; the rest is random noise
  function automatic radio_event_t pick_event();
    radio_event_t ev;
    int           roll;
    int           lim;
    ev.op   = 3'($urandom_range(0, 7));
    ev.ts   = rand40();
    ev.flen = 10'($urandom_range(0, 1023));
    ev.fctl = 16'($urandom);
    ev.pan  = 16'($urandom);
    ev.anc  = 8'($urandom);
    ev.tag  = 8'($urandom);
    ev.code = 24'($urandom);
    roll = int'($urandom_range(0, 99));
    lim  = (reg_maxlen < 10) ? 10 : int'(reg_maxlen);
    if (roll < 12) return ev;
    case (ph)
      dtwr_pkg::PH_IDLE: ev.op = dtwr_pkg::OP_START;
      dtwr_pkg::PH_POLL: begin
        if (roll < 45) ev.op = dtwr_pkg::OP_TX_DONE;
        else if (roll < 88) ev = response_frame(ev.ts);
        else ev.op = fault_op();
      end
      dtwr_pkg::PH_FINAL, dtwr_pkg::PH_TURN: begin
        if (roll < 78) ev.op = dtwr_pkg::OP_TX_DONE;
        else if (roll < 88) ev.op = dtwr_pkg::OP_RX_GOOD;
        else ev.op = fault_op();
      end
      dtwr_pkg::PH_WAIT: begin
        if (roll < 70) begin
          ev.op = dtwr_pkg::OP_TICK_MS;
        end else if (roll < 80) begin
          ev = make_event(dtwr_pkg::OP_RX_GOOD, ev.ts, 10'($urandom_range(10, lim)),
                          dtwr_pkg::CODE_TURN);
        end else if (roll < 86) begin
          ev.op = dtwr_pkg::OP_RX_GOOD;
          if (reg_maxlen != 10'h3FF)
            ev.flen = 10'($urandom_range(int'(reg_maxlen) + 1, 1023));
        end else if (roll < 94) begin
          ev.op = ($urandom_range(0, 1) == 0) ? dtwr_pkg::OP_RX_ERROR : dtwr_pkg::OP_RX_GOOD;
        end else begin
          ev.op = dtwr_pkg::OP_RX_TIMEOUT;
        end
      end
      default: ;
    endcase
    return ev;
  endfunction

  // Offer one event; returns at the falling edge after it was taken
  task automatic send_radio_event(input radio_event_t ev);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ev.op;
    s_axis_tdata  <= {6'd0, ev.code, ev.tag, ev.anc, ev.pan, ev.fctl, ev.flen, ev.ts};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_cmds.push_back(predict_command(ev));
    @(negedge clk);
  endtask

  task automatic sender_idle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_results_done();
    while (expected_cmds.size() != 0) @(negedge clk);
  endtask

  task automatic run_traffic(input int count);
    repeat (count) send_radio_event(pick_event());
  endtask

  task automatic write_register(input logic [2:0] index, input logic [39:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      dtwr_pkg::REG_TAG_ID:       reg_tag     = value[7:0];
      dtwr_pkg::REG_REPLY_DELAY:  reg_reply   = value;
      dtwr_pkg::REG_ANT_DELAY:    reg_ant     = value[15:0];
      dtwr_pkg::REG_TURN_TIMEOUT: reg_timeout = value[15:0];
      dtwr_pkg::REG_MAX_LEN:      reg_maxlen  = value[9:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] tag, input logic [39:0] reply,
                                input logic [15:0] ant, input logic [15:0] tmo,
                                input logic [9:0] maxlen);
    write_register(dtwr_pkg::REG_TAG_ID, {32'd0, tag});
    write_register(dtwr_pkg::REG_REPLY_DELAY, reply);
    write_register(dtwr_pkg::REG_ANT_DELAY, {24'd0, ant});
    write_register(dtwr_pkg::REG_TURN_TIMEOUT, {24'd0, tmo});
    write_register(dtwr_pkg::REG_MAX_LEN, {30'd0, maxlen});
  endtask

  // Random settings with the extremes mixed in; turn timeout kept short mostly
  task automatic configure_random();
    logic [7:0]  tag;
    logic [39:0] reply;
    logic [15:0] ant;
    logic [15:0] tmo;
    logic [9:0]  maxlen;
    tag   = ($urandom_range(0, 5) == 0) ? 8'hFF : 8'($urandom);
    reply = rand40();
    ant   = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom);
    tmo   = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(0, 30));
    case ($urandom_range(0, 7))
      0: maxlen = 10'($urandom_range(0, 12));
      1: maxlen = 10'h3FF;
      default: maxlen = 10'($urandom_range(10, 1023));
    endcase
    apply_settings(tag, reply, ant, tmo, maxlen);
  endtask

  // --------------------------------------------------------------- tests
  // Walk every phase and event kind under the reset register values
  task automatic test_directed_events();
    send_radio_event(make_event(dtwr_pkg::OP_TX_DONE, '1, 10'd10, dtwr_pkg::CODE_RESP));
    send_radio_event(make_event(OP_UNUSED, '0, 10'd0, '0));                         // unused op
    send_radio_event(make_event(dtwr_pkg::OP_RX_GOOD, '0, 10'd10, dtwr_pkg::CODE_RESP));
    send_radio_event(make_event(dtwr_pkg::OP_START, '0, 10'd0, '0));
    send_radio_event(make_event(dtwr_pkg::OP_TX_DONE, '1, 10'd0, '0));              // poll ts
    send_radio_event(make_event(dtwr_pkg::OP_RX_GOOD, '1, 10'd10, dtwr_pkg::CODE_RESP)); // wrap
    send_radio_event(make_event(dtwr_pkg::OP_RX_GOOD, '0, 10'd10, dtwr_pkg::CODE_RESP));
    send_radio_event(make_event(dtwr_pkg::OP_TX_DONE, '0, 10'd0, '0));              // final sent
    send_radio_event(make_event(dtwr_pkg::OP_RX_GOOD, '0, 10'd128, dtwr_pkg::CODE_RESP));
    send_radio_event(make_event(dtwr_pkg::OP_RX_GOOD, '0, 10'd10, dtwr_pkg::CODE_TURN));
    send_radio_event(make_event(dtwr_pkg::OP_TX_REJECTED, '0, 10'd0, '0));          // turn rej
    send_radio_event(make_event(dtwr_pkg::OP_TICK_MS, '0, 10'd0, '0));
    send_radio_event(make_event(dtwr_pkg::OP_RX_ERROR, '0, 10'd0, '0));
    send_radio_event(make_event(dtwr_pkg::OP_RX_GOOD, '0, 10'h3FF, dtwr_pkg::CODE_TURN));
    send_radio_event(make_event(dtwr_pkg::OP_RX_GOOD, '0, 10'd10, dtwr_pkg::CODE_TURN));
    send_radio_event(make_event(dtwr_pkg::OP_TX_REJECTED, '0, 10'd0, '0));          // poll rej
    send_radio_event(make_event(dtwr_pkg::OP_RX_TIMEOUT, '0, 10'd0, '0));
    send_radio_event(make_event(dtwr_pkg::OP_TX_DONE, '0, 10'd0, '0));              // turn sent
    send_radio_event(make_event(dtwr_pkg::OP_RX_GOOD, '0, 10'd9, dtwr_pkg::CODE_TURN));
    send_radio_event(make_event(dtwr_pkg::OP_RX_TIMEOUT, '0, 10'd0, '0));           // timeout
    send_radio_event(make_event(dtwr_pkg::OP_TX_DONE, '0, 10'd0, '0));
    send_radio_event(make_event(dtwr_pkg::OP_RX_GOOD, '0, 10'd127, dtwr_pkg::CODE_RESP));
    send_radio_event(make_event(dtwr_pkg::OP_TX_REJECTED, '0, 10'd0, '0));          // final rej
    send_radio_event(make_event(dtwr_pkg::OP_RX_ERROR, '0, 10'd0, '0));
    send_radio_event(make_event(dtwr_pkg::OP_START, '0, 10'd0, '0));                // restart
    sender_idle();
    wait_results_done();
  endtask

  task automatic test_register_extremes();
    apply_settings('0, '0, '0, '0, '0);
    run_traffic(80);
    sender_idle();
    wait_results_done();
    apply_settings('1, '1, '1, '1, '1);
    run_traffic(80);
    sender_idle();
    wait_results_done();
  endtask

  task automatic test_random_ranging();
    for (int p = 0; p < 6; p++) begin
      configure_random();
      run_traffic(90);
      // sender stops until the block has answered everything
      if (p == 2) begin
        sender_idle();
        wait_results_done();
      end
      run_traffic(90);
      sender_idle();
      wait_results_done();
    end
  endtask

  // Receiver holds off long enough for the block to stall its input
  task automatic test_result_backpressure();
    configure_random();
    hold_request = 40;
    run_traffic(100);
    sender_idle();
    wait_results_done();
  endtask

  task automatic test_steady_stream();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    configure_random();
    run_traffic(150);
    sender_idle();
    wait_results_done();
  endtask

  // ----------------------------------------------------------- receiver
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
        m_axis_tready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [39:0] want, input logic [39:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted result with the oldest predicted command
  always @(posedge clk) begin : compare_results
    radio_cmd_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected result, expected nothing, actual cmd %0d data %h",
                 $time, m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_cmds.pop_front();
        check_field("command", 40'(want.cmd), 40'(m_axis_tuser));
        check_field("target_id", 40'(want.target), 40'(m_axis_tdata[1:0]));
        check_field("sequence_number", 40'(want.seq), 40'(m_axis_tdata[9:2]));
        check_field("delayed_tx_time", 40'(want.dly), 40'(m_axis_tdata[41:10]));
        check_field("poll_sent_time", want.pst, m_axis_tdata[81:42]);
        check_field("response_time", want.rsp, m_axis_tdata[121:82]);
        check_field("final_sent_time", want.fst, m_axis_tdata[161:122]);
        check_field("phase_out", 40'(want.phase), 40'(m_axis_tdata[164:162]));
      end
    end
  end

  // Watchdog on cycles without any handshake
  initial begin
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_events();
    test_register_extremes();
    test_random_ranging();
    test_result_backpressure();
    test_steady_stream();
    repeat (6) @(negedge clk);
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
